@@ rtl/rbt_pkg.sv @@
// Shared types and constants for the box table nearest-hit tracer.
// Used by rbt_ctrl, rbt_datapath and the top level; depends on nothing.
package rbt_pkg;

  // item function codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_TRACE = 2'd2;

  // box kind codes
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_DOOR  = 2'd2;

  // slab order
  localparam logic [1:0] SLAB_LEFT   = 2'd0;
  localparam logic [1:0] SLAB_RIGHT  = 2'd1;
  localparam logic [1:0] SLAB_TOP    = 2'd2;
  localparam logic [1:0] SLAB_BOTTOM = 2'd3;

  // shared multiplier operand selects
  localparam logic [2:0] MUL_RN_DEN = 3'd0;
  localparam logic [2:0] MUL_NUM_RD = 3'd1;
  localparam logic [2:0] MUL_LN_HD  = 3'd2;
  localparam logic [2:0] MUL_HN_LD  = 3'd3;
  localparam logic [2:0] MUL_DX_T   = 3'd4;
  localparam logic [2:0] MUL_DY_T   = 3'd5;
  localparam logic [2:0] MUL_SX_SX  = 3'd6;
  localparam logic [2:0] MUL_SY_SY  = 3'd7;

  localparam int XW  = 24;  // ray coordinate, Q16.8
  localparam int DW  = 25;  // ray delta and hit point
  localparam int QW  = 27;  // slab distance q and clip numerator
  localparam int NW  = 25;  // clip fraction numerator/denominator
  localparam int RMW = 26;  // divider remainder
  localparam int MAW = 27;  // multiplier operand a
  localparam int MBW = 26;  // multiplier operand b
  localparam int MPW = 53;  // product
  localparam int BDW = 50;  // squared distance as kept
  localparam int DSW = 52;  // squared distance at the port
  localparam int RECW = 65; // stored entry: solid bit and rectangle

  typedef struct packed {
    logic       take;       // input transaction accepted
    logic       rd_issue;   // read table entry at idx
    logic       box_init;   // clip range to [0,1]
    logic [1:0] slab;
    logic       slab_load;  // register rn, rd, sign of p
    logic       mul_en;
    logic [2:0] mul_op;
    logic       phase;      // 0: bound tested for rejection, 1: bound to tighten
    logic       bound_upd;
    logic       div_init;
    logic       div_step;
    logic       cap_sxy;
    logic       best_upd;
    logic       idx_inc;
    logic       out_load;
  } rbt_cmd_t;

  typedef struct packed {
    logic ray_zero;
    logic idx_done;
    logic solid;
    logic pzero;
    logic qneg;
    logic pneg;
    logic s_gt_p;
    logic s_lt_p;
  } rbt_sts_t;

endpackage

@@ rtl/ray_box_table_nearest_hit.sv @@
// Box table with nearest-hit segment tracing. Clear and load transactions
// pass straight to the output stage. A trace walks the stored boxes one at a
// time through a shared 27x26 multiplier and a one-bit-per-cycle divider;
// non-solid boxes are skipped, and a solid box that a slab test rejects
// leaves early, before the divide and the scoring.
// A new item is taken while the previous result still waits at the output.
module ray_box_table_nearest_hit import rbt_pkg::*; #(
  parameter int BOX_SLOTS   = 256,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic signed [15:0]   box_x,
  input  logic signed [15:0]   box_y,
  input  logic signed [15:0]   box_w,
  input  logic signed [15:0]   box_h,
  input  logic [1:0]           box_kind,
  input  logic                 box_enabled,
  input  logic                 box_hidden,
  input  logic signed [XW-1:0] ray_x0,
  input  logic signed [XW-1:0] ray_y0,
  input  logic signed [XW-1:0] ray_x1,
  input  logic signed [XW-1:0] ray_y1,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic signed [DW-1:0] hit_x,
  output logic signed [DW-1:0] hit_y,
  output logic [DSW-1:0]       hit_dsq,
  output logic                 box_stored,
  output logic                 table_full
);

  rbt_cmd_t cmd;
  rbt_sts_t sts;

  rbt_ctrl #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbt_datapath #(
    .BOX_SLOTS  (BOX_SLOTS),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .func       (func),
    .box_x      (box_x),
    .box_y      (box_y),
    .box_w      (box_w),
    .box_h      (box_h),
    .box_kind   (box_kind),
    .box_enabled(box_enabled),
    .box_hidden (box_hidden),
    .ray_x0     (ray_x0),
    .ray_y0     (ray_y0),
    .ray_x1     (ray_x1),
    .ray_y1     (ray_y1),
    .hit        (hit),
    .hit_x      (hit_x),
    .hit_y      (hit_y),
    .hit_dsq    (hit_dsq),
    .box_stored (box_stored),
    .table_full (table_full)
  );

endmodule

@@ rtl/rbt_ctrl.sv @@
// Sequencer for the box table tracer: accepts items, steps the datapath through
// slab tests, the t divide and the hit scoring, and owns the output valid.
// Depends on rbt_pkg.
module rbt_ctrl import rbt_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] func,
  output logic     out_valid,
  input  logic     out_ready,
  input  rbt_sts_t sts,
  output rbt_cmd_t cmd
);

  localparam int CNTW = $clog2(T_FRAC_BITS + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_NEXT = 5'd1;
  localparam logic [4:0] S_BOX  = 5'd2;
  localparam logic [4:0] S_SLAB = 5'd3;
  localparam logic [4:0] S_M1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_C1   = 5'd6;
  localparam logic [4:0] S_M3   = 5'd7;
  localparam logic [4:0] S_M4   = 5'd8;
  localparam logic [4:0] S_C2   = 5'd9;
  localparam logic [4:0] S_FM1  = 5'd10;
  localparam logic [4:0] S_FM2  = 5'd11;
  localparam logic [4:0] S_FC   = 5'd12;
  localparam logic [4:0] S_DIV  = 5'd13;
  localparam logic [4:0] S_SC1  = 5'd14;
  localparam logic [4:0] S_SC2  = 5'd15;
  localparam logic [4:0] S_SC3  = 5'd16;
  localparam logic [4:0] S_SC4  = 5'd17;
  localparam logic [4:0] S_SC5  = 5'd18;
  localparam logic [4:0] S_SC6  = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;

  logic [4:0]      state, state_next;
  logic [1:0]      slab, slab_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slab      <= SLAB_LEFT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      slab      <= slab_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    slab_next  = slab;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.slab   = slab;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (func == FUNC_TRACE && !sts.ray_zero) state_next = S_NEXT;
          else state_next = S_FIN;
        end
      end
      S_NEXT: begin
        if (sts.idx_done) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_BOX;
        end
      end
      S_BOX: begin
        if (!sts.solid) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_NEXT;
        end else begin
          cmd.box_init = 1'b1;
          slab_next    = SLAB_LEFT;
          state_next   = S_SLAB;
        end
      end
      S_SLAB: begin
        cmd.slab_load = 1'b1;
        if (sts.pzero) begin
          // parallel to this slab: start must lie inside it
          if (sts.qneg) begin
            cmd.idx_inc = 1'b1;
            state_next  = S_NEXT;
          end else if (slab == SLAB_BOTTOM) begin
            state_next = S_FM1;
          end else begin
            slab_next = slab + 2'd1;
          end
        end else begin
          state_next = S_M1;
        end
      end
      S_M1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_RN_DEN;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_NUM_RD;
        state_next = S_C1;
      end
      S_C1: begin
        if (sts.pneg ? sts.s_gt_p : sts.s_lt_p) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_NEXT;
        end else begin
          state_next = S_M3;
        end
      end
      S_M3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_RN_DEN;
        cmd.phase  = 1'b1;
        state_next = S_M4;
      end
      S_M4: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_NUM_RD;
        cmd.phase  = 1'b1;
        state_next = S_C2;
      end
      S_C2: begin
        cmd.phase     = 1'b1;
        cmd.bound_upd = sts.pneg ? sts.s_gt_p : sts.s_lt_p;
        if (slab == SLAB_BOTTOM) begin
          state_next = S_FM1;
        end else begin
          slab_next  = slab + 2'd1;
          state_next = S_SLAB;
        end
      end
      S_FM1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LN_HD;
        state_next = S_FM2;
      end
      S_FM2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_HN_LD;
        state_next = S_FC;
      end
      S_FC: begin
        if (sts.s_gt_p) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_NEXT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = CNTW'(T_FRAC_BITS);
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = S_SC1;
        else cnt_next = cnt - 1'b1;
      end
      S_SC1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_DX_T;
        state_next = S_SC2;
      end
      S_SC2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_DY_T;
        state_next = S_SC3;
      end
      S_SC3: begin
        cmd.cap_sxy = 1'b1;
        state_next  = S_SC4;
      end
      S_SC4: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SX_SX;
        state_next = S_SC5;
      end
      S_SC5: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SY_SY;
        state_next = S_SC6;
      end
      S_SC6: begin
        cmd.best_upd = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_NEXT;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken transaction");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after accept");
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.rd_issue, cmd.mul_en, cmd.div_step, cmd.best_upd, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

@@ rtl/rbt_datapath.sv @@
// Datapath for the box table tracer: box memory, clip fractions, shared
// multiplier, restoring divider for t, best-hit and result registers.
// Depends on rbt_pkg; sequenced by rbt_ctrl.
module rbt_datapath import rbt_pkg::*; #(
  parameter int BOX_SLOTS   = 256,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rbt_cmd_t               cmd,
  output rbt_sts_t               sts,
  input  logic [1:0]             func,
  input  logic signed [15:0]     box_x,
  input  logic signed [15:0]     box_y,
  input  logic signed [15:0]     box_w,
  input  logic signed [15:0]     box_h,
  input  logic [1:0]             box_kind,
  input  logic                   box_enabled,
  input  logic                   box_hidden,
  input  logic signed [XW-1:0]   ray_x0,
  input  logic signed [XW-1:0]   ray_y0,
  input  logic signed [XW-1:0]   ray_x1,
  input  logic signed [XW-1:0]   ray_y1,
  output logic                   hit,
  output logic signed [DW-1:0]   hit_x,
  output logic signed [DW-1:0]   hit_y,
  output logic [DSW-1:0]         hit_dsq,
  output logic                   box_stored,
  output logic                   table_full
);

  localparam int IW = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;
  localparam int CW = $clog2(BOX_SLOTS + 1);
  localparam int TW = T_FRAC_BITS + 1;

  logic [RECW-1:0] mem [BOX_SLOTS];
  logic [RECW-1:0] rd_q;
  logic [CW-1:0]   count, idx;

  logic signed [XW-1:0]  x0, y0;
  logic signed [DW-1:0]  dx, dy;
  logic signed [QW-1:0]  rn;
  logic [NW-1:0]         rd;
  logic                  pneg;
  logic [NW-1:0]         lo_num, lo_den, hi_num, hi_den;
  logic signed [MPW-1:0] s_r, p_r;
  logic [RMW-1:0]        rem;
  logic [TW-1:0]         tq;
  logic signed [DW-1:0]  sx, sy;
  logic                  found, stored, full;
  logic signed [DW-1:0]  best_x, best_y;
  logic [BDW-1:0]        best_d;

  // load decode
  logic keep, solid_in, has_room, wr_en;
  assign keep = !box_w[15] && (box_w != '0) && !box_h[15] && (box_h != '0) &&
                (!box_hidden || box_kind == KIND_DOOR);
  assign solid_in = (box_kind == KIND_WALL) || (box_kind == KIND_DOOR && box_enabled);
  assign has_room = (count < CW'(BOX_SLOTS));
  assign wr_en    = cmd.take && (func == FUNC_LOAD) && keep && has_room;

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IW-1:0]] <= {solid_in, box_h, box_w, box_y, box_x};
    if (cmd.rd_issue) rd_q <= mem[idx[IW-1:0]];
  end

  // box edges in Q16.8
  logic signed [QW-1:0] bl, bt, br, bb, x0e, y0e, q;
  logic signed [DW:0]   p;
  assign bl  = {{3{rd_q[15]}}, rd_q[15:0], 8'h00};
  assign bt  = {{3{rd_q[31]}}, rd_q[31:16], 8'h00};
  assign br  = bl + {{3{rd_q[47]}}, rd_q[47:32], 8'h00};
  assign bb  = bt + {{3{rd_q[63]}}, rd_q[63:48], 8'h00};
  assign x0e = QW'(x0);
  assign y0e = QW'(y0);

  always_comb begin
    unique case (cmd.slab)
      SLAB_LEFT: begin
        p = -(DW + 1)'(dx);
        q = x0e - bl;
      end
      SLAB_RIGHT: begin
        p = (DW + 1)'(dx);
        q = br - x0e;
      end
      SLAB_TOP: begin
        p = -(DW + 1)'(dy);
        q = y0e - bt;
      end
      default: begin
        p = (DW + 1)'(dy);
        q = bb - y0e;
      end
    endcase
  end

  // shared multiplier
  logic                 sel_hi;
  logic [NW-1:0]        b_num, b_den;
  logic signed [MAW-1:0] ma;
  logic signed [MBW-1:0] mb;
  assign sel_hi = pneg ^ cmd.phase;
  assign b_num  = sel_hi ? hi_num : lo_num;
  assign b_den  = sel_hi ? hi_den : lo_den;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_RN_DEN: begin
        ma = rn;
        mb = {1'b0, b_den};
      end
      MUL_NUM_RD: begin
        ma = {2'b00, b_num};
        mb = {1'b0, rd};
      end
      MUL_LN_HD: begin
        ma = {2'b00, lo_num};
        mb = {1'b0, hi_den};
      end
      MUL_HN_LD: begin
        ma = {2'b00, hi_num};
        mb = {1'b0, lo_den};
      end
      MUL_DX_T: begin
        ma = MAW'(dx);
        mb = MBW'(tq);
      end
      MUL_DY_T: begin
        ma = MAW'(dy);
        mb = MBW'(tq);
      end
      MUL_SX_SX: begin
        ma = MAW'(sx);
        mb = MBW'(sx);
      end
      default: begin
        ma = MAW'(sy);
        mb = MBW'(sy);
      end
    endcase
  end

  // product times t, shifted down with truncation toward zero
  function automatic logic signed [DW-1:0] scale_trunc(input logic signed [MPW-1:0] v);
    logic [MPW-1:0] mag, sh;
    mag = v[MPW-1] ? MPW'(-v) : MPW'(v);
    sh  = mag >> T_FRAC_BITS;
    return v[MPW-1] ? DW'(-sh) : DW'(sh);
  endfunction

  logic           dge;
  logic [RMW-1:0] rsub;
  logic [BDW-1:0] cand_d;
  assign dge    = rem >= {1'b0, lo_den};
  assign rsub   = dge ? (rem - {1'b0, lo_den}) : rem;
  assign cand_d = s_r[BDW-1:0] + p_r[BDW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.take && func == FUNC_CLEAR) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      found  <= 1'b0;
      best_x <= '0;
      best_y <= '0;
      best_d <= '0;
      stored <= wr_en;
      full   <= (func == FUNC_LOAD) && keep && !has_room;
      if (func == FUNC_TRACE) begin
        x0  <= ray_x0;
        y0  <= ray_y0;
        dx  <= DW'(ray_x1) - DW'(ray_x0);
        dy  <= DW'(ray_y1) - DW'(ray_y0);
        idx <= '0;
      end
    end
    if (cmd.idx_inc) idx <= idx + 1'b1;
    if (cmd.box_init) begin
      lo_num <= '0;
      lo_den <= NW'(1);
      hi_num <= NW'(1);
      hi_den <= NW'(1);
    end
    if (cmd.slab_load) begin
      pneg <= p[DW];
      rd   <= p[DW] ? NW'(-p) : NW'(p);
      rn   <= p[DW] ? -q : q;
    end
    if (cmd.bound_upd) begin
      if (sel_hi) begin
        hi_num <= rn[NW-1:0];
        hi_den <= rd;
      end else begin
        lo_num <= rn[NW-1:0];
        lo_den <= rd;
      end
    end
    if (cmd.mul_en) begin
      s_r <= p_r;
      p_r <= MPW'(ma) * MPW'(mb);
    end
    if (cmd.div_init) begin
      rem <= {1'b0, lo_num};
      tq  <= '0;
    end
    if (cmd.div_step) begin
      rem <= {rsub[RMW-2:0], 1'b0};
      tq  <= {tq[TW-2:0], dge};
    end
    if (cmd.cap_sxy) begin
      sx <= scale_trunc(s_r);
      sy <= scale_trunc(p_r);
    end
    if (cmd.best_upd && (!found || cand_d < best_d)) begin
      found  <= 1'b1;
      best_x <= DW'(x0) + sx;
      best_y <= DW'(y0) + sy;
      best_d <= cand_d;
    end
    if (cmd.out_load) begin
      hit        <= found;
      hit_x      <= best_x;
      hit_y      <= best_y;
      hit_dsq    <= DSW'(best_d);
      box_stored <= stored;
      table_full <= full;
    end
  end

  assign sts.ray_zero = (ray_x0 == ray_x1) && (ray_y0 == ray_y1);
  assign sts.idx_done = (idx >= count);
  assign sts.solid    = rd_q[RECW-1];
  assign sts.pzero    = (p == '0);
  assign sts.qneg     = q[QW-1];
  assign sts.pneg     = pneg;
  assign sts.s_gt_p   = s_r > p_r;
  assign sts.s_lt_p   = s_r < p_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(BOX_SLOTS))
    else $error("table count beyond capacity");
`endif

endmodule

@@ test/tb_ray_box_table_nearest_hit.sv @@
// Self-checking testbench for ray_box_table_nearest_hit: directed and random
// clear/load/trace transactions, with random gaps on input and output sides.
// Depends on rbt_pkg and the ray_box_table_nearest_hit RTL.
module tb_ray_box_table_nearest_hit import rbt_pkg::*; ();

  localparam int SLOTS = 256;
  localparam int TFB   = 16;

  typedef struct {
    logic [1:0]         func;
    logic signed [15:0] bx, by, bw, bh;
    logic [1:0]         kind;
    logic               en, hid;
    logic signed [23:0] x0, y0, x1, y1;
  } item_t;

  typedef struct {
    logic               hit;
    logic signed [24:0] hx, hy;
    logic [51:0]        dsq;
    logic               stored, full;
  } res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic [1:0] func = 0, box_kind = 0;
  logic signed [15:0] box_x = 0, box_y = 0, box_w = 0, box_h = 0;
  logic box_enabled = 0, box_hidden = 0;
  logic signed [23:0] ray_x0 = 0, ray_y0 = 0, ray_x1 = 0, ray_y1 = 0;
  logic hit, box_stored, table_full;
  logic signed [24:0] hit_x, hit_y;
  logic [51:0] hit_dsq;

  ray_box_table_nearest_hit dut (.*);

  always #1 clk = ~clk;

  // predictor copy of the box table
  longint tab_x[SLOTS], tab_y[SLOTS], tab_w[SLOTS], tab_h[SLOTS];
  bit     tab_solid[SLOTS];
  int     tab_count = 0;

  res_t pending_results[$];
  int   errors = 0;
  bit   quiet = 0;
  int   sent = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit clip_slab(longint p, longint q, inout longint ln, ld, hn, hd);
    longint rn, rd;
    rn = q;
    rd = p;
    if (p == 0) return q >= 0;
    if (rd < 0) begin
      rn = -rn;
      rd = -rd;
    end
    if (p < 0) begin
      if (rn * hd > hn * rd) return 0;
      if (rn * ld > ln * rd) begin
        ln = rn;
        ld = rd;
      end
    end else begin
      if (rn * ld < ln * rd) return 0;
      if (rn * hd < hn * rd) begin
        hn = rn;
        hd = rd;
      end
    end
    return 1;
  endfunction

  function automatic longint scale_t(longint d, longint t);
    longint prod, mag;
    prod = d * t;
    mag = (prod < 0) ? -prod : prod;
    mag = mag >> TFB;
    return (prod < 0) ? -mag : mag;
  endfunction

  function automatic res_t nearest_hit(item_t it);
    res_t r;
    longint x0, y0, dx, dy, bl, bt, br, bb, ln, ld, hn, hd, t, hx, hy, ex, ey;
    longint unsigned cand_d, best;
    bit found;
    bit keep;
    r = '{default: 0};
    found = 0;
    best = 0;
    if (it.func == FUNC_CLEAR) begin
      tab_count = 0;
    end else if (it.func == FUNC_LOAD) begin
      keep = it.bw > 0 && it.bh > 0 && (!it.hid || it.kind == KIND_DOOR);
      if (keep) begin
        if (tab_count >= SLOTS) begin
          r.full = 1;
        end else begin
          tab_x[tab_count] = it.bx;
          tab_y[tab_count] = it.by;
          tab_w[tab_count] = it.bw;
          tab_h[tab_count] = it.bh;
          tab_solid[tab_count] = it.kind == KIND_WALL || (it.kind == KIND_DOOR && it.en);
          tab_count++;
          r.stored = 1;
        end
      end
    end else if (it.func == FUNC_TRACE) begin
      x0 = it.x0;
      y0 = it.y0;
      dx = longint'(it.x1) - x0;
      dy = longint'(it.y1) - y0;
      if (dx != 0 || dy != 0) begin
        for (int i = 0; i < tab_count; i++) begin
          if (!tab_solid[i]) continue;
          ln = 0; ld = 1; hn = 1; hd = 1;
          bl = tab_x[i] * 256;
          bt = tab_y[i] * 256;
          br = bl + tab_w[i] * 256;
          bb = bt + tab_h[i] * 256;
          if (!clip_slab(-dx, x0 - bl, ln, ld, hn, hd)) continue;
          if (!clip_slab(dx, br - x0, ln, ld, hn, hd)) continue;
          if (!clip_slab(-dy, y0 - bt, ln, ld, hn, hd)) continue;
          if (!clip_slab(dy, bb - y0, ln, ld, hn, hd)) continue;
          if (ln * hd > hn * ld) continue;
          t = (ln << TFB) / ld;
          hx = x0 + scale_t(dx, t);
          hy = y0 + scale_t(dy, t);
          ex = hx - x0;
          ey = hy - y0;
          cand_d = longint'(ex * ex) + longint'(ey * ey);
          if (!found || cand_d < best) begin
            found = 1;
            best = cand_d;
            r.hx = hx[24:0];
            r.hy = hy[24:0];
          end
        end
      end
      if (found) begin
        r.hit = 1;
        r.dsq = best[51:0];
      end
    end
    return r;
  endfunction

  task automatic send(item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    func <= it.func;
    box_x <= it.bx; box_y <= it.by; box_w <= it.bw; box_h <= it.bh;
    box_kind <= it.kind; box_enabled <= it.en; box_hidden <= it.hid;
    ray_x0 <= it.x0; ray_y0 <= it.y0; ray_x1 <= it.x1; ray_y1 <= it.y1;
    in_valid <= 1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_results = {pending_results, nearest_hit(it)};
    sent++;
  endtask

  function automatic item_t noise_item();
    item_t it;
    it.func = 2'($urandom); it.kind = 2'($urandom);
    it.en = 1'($urandom); it.hid = 1'($urandom);
    it.bx = 16'($urandom); it.by = 16'($urandom);
    it.bw = 16'($urandom); it.bh = 16'($urandom);
    it.x0 = 24'($urandom); it.y0 = 24'($urandom);
    it.x1 = 24'($urandom); it.y1 = 24'($urandom);
    return it;
  endfunction

  function automatic item_t load_item(int x, int y, int w, int h, logic [1:0] k,
                                      bit e, bit hd);
    item_t it;
    it = noise_item();
    it.func = FUNC_LOAD;
    it.bx = 16'(x); it.by = 16'(y); it.bw = 16'(w); it.bh = 16'(h);
    it.kind = k; it.en = e; it.hid = hd;
    return it;
  endfunction

  function automatic item_t trace_item(int x0, int y0, int x1, int y1);
    item_t it;
    it = noise_item();
    it.func = FUNC_TRACE;
    it.x0 = 24'(x0); it.y0 = 24'(y0); it.x1 = 24'(x1); it.y1 = 24'(y1);
    return it;
  endfunction

  function automatic item_t clear_item();
    item_t it;
    it = noise_item();
    it.func = FUNC_CLEAR;
    return it;
  endfunction

  function automatic item_t rand_load();
    if ($urandom_range(0, 9) == 0)
      return load_item($urandom, $urandom, $urandom, $urandom,
                       2'($urandom), 1'($urandom), 1'($urandom));
    return load_item($urandom_range(0, 120) - 60, $urandom_range(0, 120) - 60,
                     $urandom_range(0, 32) - 2, $urandom_range(0, 32) - 2,
                     2'($urandom_range(0, 3)), 1'($urandom), $urandom_range(0, 3) == 0);
  endfunction

  function automatic item_t rand_trace();
    item_t it;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return trace_item($urandom, $urandom, $urandom, $urandom);
    it = trace_item($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                    $urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000);
    if (r < 3) it.y1 = it.y0;          // horizontal
    else if (r < 5) it.x1 = it.x0;     // vertical
    else if (r == 5) begin
      it.x1 = it.x0;
      it.y1 = it.y0;
    end
    return it;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // output side: random stalls, check each transaction that completes next edge
  int stall = 0;
  always @(posedge clk) begin
    if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= 0;
    end else begin
      stall <= gap_len();
      out_ready <= 1;
    end
  end

  always @(negedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (hit !== e.hit) report("hit", hit, e.hit);
        if (hit_x !== e.hx) report("hit_x", hit_x[24:0], e.hx[24:0]);
        if (hit_y !== e.hy) report("hit_y", hit_y[24:0], e.hy[24:0]);
        if (hit_dsq !== e.dsq) report("hit_dsq", hit_dsq, e.dsq);
        if (box_stored !== e.stored) report("box_stored", box_stored, e.stored);
        if (table_full !== e.full) report("table_full", table_full, e.full);
      end
    end
  end

  task automatic test_load_rules();
    send(clear_item());
    send(load_item(0, 0, 10, 10, KIND_WALL, 0, 0));
    send(load_item(20, 0, 5, 5, KIND_DOOR, 1, 0));
    send(load_item(40, 0, 5, 5, KIND_DOOR, 0, 0));       // open door, not solid
    send(load_item(60, 0, 5, 5, KIND_WALL, 0, 1));       // hidden wall dropped
    send(load_item(80, 0, 5, 5, KIND_DOOR, 1, 1));       // hidden door kept
    send(load_item(0, 40, 0, 5, KIND_WALL, 0, 0));
    send(load_item(0, 40, 5, -1, KIND_WALL, 0, 0));
    send(load_item(0, 40, 5, 5, 2'd3, 1, 0));            // kind 3 never solid
    send(load_item(0, 60, 5, 5, KIND_OTHER, 1, 0));
    send(load_item(-32768, -32768, 32767, 32767, KIND_WALL, 0, 0));
  endtask

  task automatic test_trace_cases();
    send(trace_item(-2560, 1280, 30000, 1280));          // horizontal through boxes
    send(trace_item(1280, 1280, 1280, 1280));            // zero length
    send(trace_item(-2560, -25600, 30000, -25600));      // parallel, starts inside the large box
    send(trace_item(1280, 1280, 40000, 30000));          // starts inside
    send(trace_item(23000, 25000, -10000, -10000));
    send(trace_item(-8388608, -8388608, 8388607, 8388607));
    send(trace_item(8388607, -8388608, -8388608, 8388607));
    begin
      item_t it;
      it = noise_item();
      it.func = 2'd3;
      send(it);
    end
    send(clear_item());
    send(trace_item(-2560, 1280, 30000, 1280));          // empty table
  endtask

  task automatic test_full_table();
    quiet = 1;
    send(clear_item());
    for (int i = 0; i < SLOTS; i++)
      send(load_item(i * 3 - 400, (i % 16) * 4, 2, 2, KIND_WALL, 0, 0));
    send(load_item(0, 0, 4, 4, KIND_WALL, 0, 0));         // refused, table full
    send(load_item(0, 0, 0, 4, KIND_WALL, 0, 0));         // dropped, no full flag
    quiet = 0;
    send(trace_item(-120000, 256, 120000, 16000));
    send(trace_item(100000, 8000, -120000, 300));
    send(clear_item());
  endtask

  task automatic test_random();
    int n;
    while (sent < 580) begin
      if ($urandom_range(0, 4) != 0) send(clear_item());
      quiet = $urandom_range(0, 5) == 0;
      n = $urandom_range(0, 10);
      repeat (n) send(rand_load());
      n = $urandom_range(1, 6);
      repeat (n) send(rand_trace());
      if ($urandom_range(0, 3) == 0) send(noise_item());
    end
    quiet = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    test_load_rules();
    test_trace_cases();
    test_full_table();
    test_random();
    @(posedge clk);
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rbt_pkg.sv
rtl/rbt_ctrl.sv
rtl/rbt_datapath.sv
rtl/ray_box_table_nearest_hit.sv
test/tb_ray_box_table_nearest_hit.sv
